### rtl/imd_pkg.sv
package imd_pkg;

  localparam int WINDOW_LEN = 16;
  localparam int WIN_AW     = $clog2(WINDOW_LEN);
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

  localparam int AXIS_W  = 16;
  // Sum of three squared 16-bit magnitudes, kept at an even width so the
  // square root consumes whole digit pairs.
  localparam int SQ_W    = 36;
  localparam int MAG_W   = 17;
  localparam int SUM_W   = 22;
  localparam int SQS_W   = 38;
  localparam int NUM_W   = 44;
  localparam int VAR_W   = 30;
  localparam int GMAG_W  = 16;

  localparam logic [2:0] REG_VAR_ENTER   = 3'd0;
  localparam logic [2:0] REG_VAR_EXIT    = 3'd1;
  localparam logic [2:0] REG_GYRO_ENTER  = 3'd2;
  localparam logic [2:0] REG_GYRO_EXIT   = 3'd3;
  localparam logic [2:0] REG_HOLD_FRAMES = 3'd4;

  // Frame held in the queue between the front and the back.
  typedef struct packed {
    logic [SQ_W-1:0] accel_sq;
    logic [SQ_W-1:0] gyro_sq;
  } frame_t;

  typedef struct packed {
    logic [VAR_W-1:0]  var_enter;
    logic [VAR_W-1:0]  var_exit;
    logic [GMAG_W-1:0] gyro_enter;
    logic [GMAG_W-1:0] gyro_exit;
    logic [7:0]        hold_frames;
  } cfg_t;

  function automatic logic [AXIS_W-1:0] abs16(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] r;
    r = v[AXIS_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

### rtl/imu_motion_detector.sv
// Path from the accepting edge of an input item to out_tvalid: axis squaring in the front,
// a hand-off through the queue, two square roots, the window update and numerator steps,
// the divider, and the decision and output steps.
// The back part takes a new item only when done with the last; the front takes the next
// item meanwhile, and a stalled result holds the back in its output step.
// Reset (rst_n low, synchronous) empties the window, selects still, and loads defaults.
module imu_motion_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // motion_state, transition flag, accel_variance,
                                  // gyro norm
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import imd_pkg::*;

  cfg_t   cfg_r;
  frame_t fr_data;
  logic   fr_valid, fr_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.var_enter   <= VAR_W'(4000);
      cfg_r.var_exit    <= VAR_W'(2000);
      cfg_r.gyro_enter  <= GMAG_W'(800);
      cfg_r.gyro_exit   <= GMAG_W'(400);
      cfg_r.hold_frames <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VAR_ENTER:   cfg_r.var_enter   <= cfg_data[VAR_W-1:0];
        REG_VAR_EXIT:    cfg_r.var_exit    <= cfg_data[VAR_W-1:0];
        REG_GYRO_ENTER:  cfg_r.gyro_enter  <= cfg_data[GMAG_W-1:0];
        REG_GYRO_EXIT:   cfg_r.gyro_exit   <= cfg_data[GMAG_W-1:0];
        REG_HOLD_FRAMES: cfg_r.hold_frames <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  imd_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .fr_valid, .fr_ready, .fr_data
  );

  imd_back u_back (
    .clk, .rst_n, .fr_valid, .fr_ready, .fr_data, .cfg(cfg_r),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

### rtl/imd_front.sv
module imd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,
  output logic                 fr_valid,
  input  logic                 fr_ready,
  output imd_pkg::frame_t      fr_data
);
  import imd_pkg::*;

  // Six-step front: squares one axis per cycle through a single multiplier.
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;

  logic [1:0]        st_r, st_nxt;
  logic [2:0]        ax_r, ax_nxt;
  logic [95:0]       buf_r, buf_nxt;
  logic [SQ_W-1:0]   acc_r, acc_nxt;
  logic [SQ_W-1:0]   asq_r, asq_nxt;
  logic              q_valid_r, q_valid_nxt;
  frame_t            q_r, q_nxt;
  logic [AXIS_W-1:0] a;
  logic [31:0]       prod;

  assign a    = abs16(buf_r[ax_r*AXIS_W +: AXIS_W]);
  assign prod = a * a;

  assign in_tready = (st_r == F_IDLE) && !q_valid_r;
  assign fr_valid  = q_valid_r;
  assign fr_data   = q_r;

  always_comb begin
    st_nxt      = st_r;
    ax_nxt      = ax_r;
    buf_nxt     = buf_r;
    acc_nxt     = acc_r;
    asq_nxt     = asq_r;
    q_valid_nxt = q_valid_r;
    q_nxt       = q_r;
    if (q_valid_r && fr_ready) q_valid_nxt = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (in_tvalid && in_tready) begin
          buf_nxt = in_tdata;
          ax_nxt  = 3'd0;
          acc_nxt = '0;
          st_nxt  = F_SQ;
        end
      end
      F_SQ: begin
        acc_nxt = acc_r + SQ_W'(prod);
        if (ax_r == 3'd2) begin
          asq_nxt = acc_r + SQ_W'(prod);
          acc_nxt = '0;
        end
        ax_nxt = ax_r + 3'd1;
        if (ax_r == 3'd5) begin
          q_nxt.accel_sq = asq_r;
          q_nxt.gyro_sq  = acc_r + SQ_W'(prod);
          q_valid_nxt    = 1'b1;
          st_nxt         = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_IDLE;
      q_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      q_valid_r <= q_valid_nxt;
    end
    ax_r  <= ax_nxt;
    buf_r <= buf_nxt;
    acc_r <= acc_nxt;
    asq_r <= asq_nxt;
    q_r   <= q_nxt;
  end

endmodule

### rtl/imd_back.sv
module imd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fr_valid,
  output logic                  fr_ready,
  input  imd_pkg::frame_t       fr_data,
  input  imd_pkg::cfg_t         cfg,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata
);
  import imd_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SQRTA = 4'd1;
  localparam logic [3:0] B_SQRTG = 4'd2;
  localparam logic [3:0] B_RD    = 4'd3;
  localparam logic [3:0] B_OLD   = 4'd4;
  localparam logic [3:0] B_NEW   = 4'd5;
  localparam logic [3:0] B_NUM1  = 4'd6;
  localparam logic [3:0] B_NUM2  = 4'd7;
  localparam logic [3:0] B_DIV   = 4'd8;
  localparam logic [3:0] B_DEC   = 4'd9;
  localparam logic [3:0] B_OUT   = 4'd10;

  logic [3:0]        st_r, st_nxt;
  logic [MAG_W:0]    root_r, root_nxt;
  logic [SQ_W-1:0]   gsq_r, gsq_nxt;
  logic [4:0]        it_r, it_nxt;
  logic [MAG_W-1:0]  amag_r, amag_nxt;
  logic [GMAG_W-1:0] gmag_r, gmag_nxt;
  logic [MAG_W-1:0]  win [WINDOW_LEN];
  logic [MAG_W-1:0]  old_r;
  logic              win_we;
  logic [WIN_AW-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQS_W-1:0]  sqs_r, sqs_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [NUM_W-1:0]  den_r, den_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [5:0]        dit_r, dit_nxt;
  logic              moving_r, moving_nxt;
  logic [7:0]        quiet_r, quiet_nxt;
  logic              chg_r, chg_nxt;
  logic              ov_r, ov_nxt;
  logic [47:0]       od_r, od_nxt;
  logic [MAG_W-1:0]  mul_a;
  logic [MAG_W-1:0]  mul_b;
  logic [2*MAG_W-1:0] mprod;
  logic [NUM_W-1:0]  dsh;
  logic [7:0]        qinc;

  always_comb begin
    mul_a = amag_r;
    mul_b = amag_r;
    if (st_r == B_OLD) begin
      mul_a = old_r;
      mul_b = old_r;
    end else if (st_r == B_NUM1) begin
      mul_a = MAG_W'(fill_r);
      mul_b = MAG_W'(fill_r);
    end
  end
  assign mprod = mul_a * mul_b;

  assign dsh  = den_r << dit_r;
  assign qinc = quiet_r + 8'd1;
  assign fr_ready  = (st_r == B_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign win_we     = (st_r == B_NEW);

  always_ff @(posedge clk) begin
    if (win_we) win[slot_r] <= amag_r;
    old_r <= win[slot_r];
  end

  // Restoring square root, one result bit per cycle: the remainder takes the
  // next digit pair of the radicand, the root is built MSB first.
  logic [SQ_W+3:0] sq_rem_r, sq_rem_nxt;
  logic [SQ_W+3:0] sq_t;
  logic [SQ_W-1:0] sq_src_r, sq_src_nxt;
  assign sq_t = {sq_rem_r[SQ_W+1:0], sq_src_r[SQ_W-1 -: 2]} - {root_r, 2'b01};

  always_comb begin
    st_nxt = st_r; root_nxt = root_r; gsq_nxt = gsq_r;
    it_nxt = it_r; amag_nxt = amag_r; gmag_nxt = gmag_r; slot_nxt = slot_r;
    fill_nxt = fill_r; sum_nxt = sum_r; sqs_nxt = sqs_r; num_nxt = num_r;
    den_nxt = den_r; quo_nxt = quo_r; dit_nxt = dit_r; moving_nxt = moving_r;
    quiet_nxt = quiet_r; chg_nxt = chg_r; ov_nxt = ov_r; od_nxt = od_r;
    sq_rem_nxt = sq_rem_r; sq_src_nxt = sq_src_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (fr_valid) begin
          sq_src_nxt = fr_data.accel_sq;
          gsq_nxt    = fr_data.gyro_sq;
          sq_rem_nxt = '0;
          root_nxt   = '0;
          it_nxt     = 5'd0;
          st_nxt     = B_SQRTA;
        end
      end
      B_SQRTA, B_SQRTG: begin
        // 36-bit radicand: 18 digit pairs.
        if (!sq_t[SQ_W+3]) begin
          sq_rem_nxt = sq_t;
          root_nxt   = {root_r[MAG_W-1:0], 1'b1};
        end else begin
          sq_rem_nxt = {sq_rem_r[SQ_W+1:0], sq_src_r[SQ_W-1 -: 2]};
          root_nxt   = {root_r[MAG_W-1:0], 1'b0};
        end
        sq_src_nxt = sq_src_r << 2;
        it_nxt     = it_r + 5'd1;
        if (it_r == 5'd17) begin
          it_nxt     = 5'd0;
          sq_rem_nxt = '0;
          if (st_r == B_SQRTA) begin
            amag_nxt   = root_nxt[MAG_W-1:0];
            root_nxt   = '0;
            sq_src_nxt = gsq_r;
            st_nxt     = B_SQRTG;
          end else begin
            gmag_nxt = root_nxt[GMAG_W-1:0];
            st_nxt   = B_RD;
          end
        end
      end
      B_RD: st_nxt = B_OLD;
      B_OLD: begin
        if (32'(fill_r) >= WINDOW_LEN) begin
          sum_nxt = sum_r - SUM_W'(old_r);
          sqs_nxt = sqs_r - SQS_W'(mprod);
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        st_nxt = B_NEW;
      end
      B_NEW: begin
        sum_nxt  = sum_r + SUM_W'(amag_r);
        sqs_nxt  = sqs_r + SQS_W'(mprod);
        slot_nxt = (32'(slot_r) == WINDOW_LEN - 1) ? '0 : slot_r + 1'b1;
        st_nxt   = B_NUM1;
      end
      B_NUM1: begin
        den_nxt = NUM_W'(mprod);
        num_nxt = NUM_W'(sqs_r) * NUM_W'(fill_r);
        st_nxt  = B_NUM2;
      end
      B_NUM2: begin
        num_nxt = num_r - NUM_W'(sum_r) * NUM_W'(sum_r);
        quo_nxt = '0;
        dit_nxt = 6'd31;
        st_nxt  = B_DIV;
      end
      B_DIV: begin
        if ((den_r << dit_r) >> dit_r == den_r && num_r >= dsh) begin
          num_nxt = num_r - dsh;
          quo_nxt = quo_r | (NUM_W'(1) << dit_r);
        end
        dit_nxt = dit_r - 6'd1;
        if (dit_r == 6'd0) st_nxt = B_DEC;
      end
      B_DEC: begin
        chg_nxt = 1'b0;
        if (!moving_r) begin
          if (quo_r[VAR_W-1:0] > cfg.var_enter || gmag_r > cfg.gyro_enter) begin
            moving_nxt = 1'b1; quiet_nxt = '0; chg_nxt = 1'b1;
          end
        end else if (quo_r[VAR_W-1:0] < cfg.var_exit && gmag_r < cfg.gyro_exit) begin
          quiet_nxt = qinc;
          if (qinc >= cfg.hold_frames) begin
            moving_nxt = 1'b0; quiet_nxt = '0; chg_nxt = 1'b1;
          end
        end else begin
          quiet_nxt = '0;
        end
        st_nxt = B_OUT;
      end
      B_OUT: begin
        if (!ov_r) begin
          od_nxt = {gmag_r, quo_r[VAR_W-1:0], chg_r, moving_r};
          ov_nxt = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; ov_r <= 1'b0; slot_r <= '0; fill_r <= '0;
      sum_r <= '0; sqs_r <= '0; moving_r <= 1'b0; quiet_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; slot_r <= slot_nxt; fill_r <= fill_nxt;
      sum_r <= sum_nxt; sqs_r <= sqs_nxt; moving_r <= moving_nxt; quiet_r <= quiet_nxt;
    end
    root_r <= root_nxt; gsq_r <= gsq_nxt; it_r <= it_nxt;
    amag_r <= amag_nxt; gmag_r <= gmag_nxt; num_r <= num_nxt; den_r <= den_nxt;
    quo_r <= quo_nxt; dit_r <= dit_nxt; chg_r <= chg_nxt; od_r <= od_nxt;
    sq_rem_r <= sq_rem_nxt; sq_src_r <= sq_src_nxt;
  end

endmodule

### rtl/imd_checker.sv
module imd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // Three 16-bit axes cannot give a norm of 56756 or more.
  a_gnorm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] < 16'd56756)
    else $error("gyro norm out of range");
  a_chg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] && out_tdata[0] |-> out_tdata[47:32] != 16'd0
      || out_tdata[31:2] != 30'd0)
    else $error("entered moving with quiet values");
endmodule

bind imu_motion_detector imd_checker u_chk (.*);
